@@ hw/rtl/bicubic_image_resampler_assert.svh @@
// Assertion macros for the bicubic resampler RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BICUBIC_IMAGE_RESAMPLER_ASSERT_SVH
`define BICUBIC_IMAGE_RESAMPLER_ASSERT_SVH

// Same-cycle implication.
`define BIR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bir assertion failed");

// Next-cycle implication.
`define BIR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bir assertion failed");

`endif

@@ hw/rtl/bir_pkg.sv @@
// Shared types, constants and arithmetic helpers of the bicubic resampler.
// No dependencies.
package bir_pkg;

  localparam int MAX_SOURCE_DIM = 512;
  localparam int MAX_TARGET_DIM = 2048;
  localparam int CHANNELS       = 3;

  localparam int SRC_IDX_W   = $clog2(MAX_SOURCE_DIM);
  localparam int SRC_DIM_W   = SRC_IDX_W + 1;
  localparam int TGT_DIM_W   = $clog2(MAX_TARGET_DIM) + 1;
  localparam int CH_W        = 2;
  localparam int COORD_W     = 11;
  localparam int PIX_W       = 8;
  localparam int VAL_W       = 24;
  localparam int STORE_DEPTH = CHANNELS * MAX_SOURCE_DIM * MAX_SOURCE_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Position divider: numerator (2o+1)*in - out over 2*out
  localparam int PROD_W   = COORD_W + 1 + SRC_DIM_W;
  localparam int NUM_W    = PROD_W + 1;
  localparam int DEN_W    = TGT_DIM_W + 1;
  localparam int FRAC_W   = 14;
  localparam int QUO_W    = PROD_W + FRAC_W;
  localparam int DCNT_W   = $clog2(QUO_W + 1);
  localparam int SPOS_W   = SRC_DIM_W + 1;

  localparam int WGT_W    = 18;
  localparam int H_W      = 28;
  localparam int VP_W     = WGT_W + H_W;
  localparam int SUM_W    = 48;
  localparam int MAG_W    = 39;
  localparam int Y_W      = 26;
  localparam int RECIP_W  = 27;
  localparam logic [RECIP_W-1:0] RECIP_255 = 27'd67372037;  // ceil(2^34 / 255)
  localparam int RECIP_SH = 34;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  localparam logic [2:0] REG_SRC_W  = 3'd0;
  localparam logic [2:0] REG_SRC_H  = 3'd1;
  localparam logic [2:0] REG_TGT_W  = 3'd2;
  localparam logic [2:0] REG_TGT_H  = 3'd3;
  localparam logic [2:0] REG_NORM   = 3'd4;
  localparam logic [2:0] REG_MEANS  = 3'd5;
  localparam logic [2:0] REG_INVSTD = 3'd6;

  typedef logic signed [WGT_W-1:0] wgt_val_t;
  typedef wgt_val_t [3:0] wgt_t;

  typedef struct packed {
    logic [SRC_DIM_W-1:0] in_w;
    logic [SRC_DIM_W-1:0] in_h;
    logic [TGT_DIM_W-1:0] out_w;
    logic [TGT_DIM_W-1:0] out_h;
    logic                 norm;
    logic [47:0]          means;
    logic [47:0]          invs;
  } cfg_t;

  typedef struct packed {
    logic       wr;
    logic       latch;
    logic       setup;
    logic       div_start;
    logic       wt2;
    logic       wt3;
    logic       wgt;
    logic       fetch;
    logic [3:0] tap;
    logic       nrm1;
    logic       nrm2;
    logic       nrm3;
    logic       nrm4;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic req_err;
    logic div_done;
    logic sum_done;
  } sts_t;

  // Divide by 2^29, round to nearest, halves away from zero.
  function automatic wgt_val_t rnd29(logic signed [47:0] x);
    logic [47:0] mag;
    logic [47:0] q;
    mag = x[47] ? 48'(-x) : 48'(x);
    q   = (mag + 48'h1000_0000) >> 29;
    return x[47] ? wgt_val_t'(-q[WGT_W-1:0]) : wgt_val_t'(q[WGT_W-1:0]);
  endfunction

  // Catmull-Rom weights in Q4.14 from t, t^2, t^3.
  function automatic wgt_t calc_weights(logic [13:0] t, logic [27:0] t2, logic [41:0] t3);
    logic signed [47:0] st;
    logic signed [47:0] st2;
    logic signed [47:0] st3;
    logic signed [47:0] n0;
    logic signed [47:0] n2;
    logic signed [47:0] n3;
    wgt_t w;
    st  = $signed({34'd0, t});
    st2 = $signed({20'd0, t2});
    st3 = $signed({6'd0, t3});
    n0  = -st3 + (st2 <<< 15) - (st <<< 28);
    n2  = -(st3 + (st3 <<< 1)) + (st2 <<< 16) + (st <<< 28);
    n3  = st3 - (st2 <<< 14);
    w[0] = rnd29(n0);
    w[2] = rnd29(n2);
    w[3] = rnd29(n3);
    w[1] = wgt_val_t'(18'sd16384 - w[0] - w[2] - w[3]);
    return w;
  endfunction

  // Edge-clamped tap index s+m-1 within [0, in-1].
  function automatic logic [SRC_IDX_W-1:0] clamp_tap(logic [SPOS_W-1:0] s, logic [1:0] m,
                                                     logic [SRC_DIM_W-1:0] in);
    logic signed [SPOS_W:0] p;
    logic [SPOS_W:0]        lim;
    p   = $signed({s[SPOS_W-1], s}) + $signed({{(SPOS_W-1){1'b0}}, m}) - 1;
    lim = {2'b00, in} - 1'b1;
    if (p[SPOS_W]) return '0;
    else if (p > $signed(lim)) return lim[SRC_IDX_W-1:0];
    else return p[SRC_IDX_W-1:0];
  endfunction

endpackage

@@ hw/rtl/bicubic_image_resampler.sv @@
// Write transfer: stored in the frame store at the accepting edge, no result.
// Compute transfer: result valid after a 36-step position divider, 16 reads of the
// single-port frame store, and weight and scaling stages; one at a time.
// Out-of-range compute: result with error set and value zero.
// Reset (rst_ni low, async): controller idle, registers at defaults; frame store undefined.
// Top level with the APB register file; depends on bir_pkg, bir_ctrl and bir_dp.
module bicubic_image_resampler import bir_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [CH_W-1:0]     channel_i,
  input  logic [COORD_W-1:0]  row_i,
  input  logic [COORD_W-1:0]  col_i,
  input  logic [PIX_W-1:0]    pixel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [VAL_W-1:0]    value_o,
  output logic [CH_W-1:0]     out_channel_o,
  output logic [COORD_W-1:0]  out_row_o,
  output logic [COORD_W-1:0]  out_col_o,
  output logic                error_o
);

  logic [9:0]  src_w_q, src_h_q;
  logic [11:0] tgt_w_q, tgt_h_q;
  logic        norm_q;
  logic [47:0] means_q, invs_q;
  logic [2:0]  idx;
  logic        wr_en;
  cfg_t        cfg;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 10'd512;
      src_h_q <= 10'd512;
      tgt_w_q <= 12'd512;
      tgt_h_q <= 12'd512;
      norm_q  <= 1'b0;
      means_q <= 48'h2000_2000_2000;
      invs_q  <= 48'h2000_2000_2000;
    end else if (wr_en) begin
      case (idx)
        REG_SRC_W:  src_w_q <= pwdata[9:0];
        REG_SRC_H:  src_h_q <= pwdata[9:0];
        REG_TGT_W:  tgt_w_q <= pwdata[11:0];
        REG_TGT_H:  tgt_h_q <= pwdata[11:0];
        REG_NORM:   norm_q  <= pwdata[0];
        REG_MEANS:  means_q <= pwdata[47:0];
        REG_INVSTD: invs_q  <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (idx)
      REG_SRC_W:  prdata = 64'(src_w_q);
      REG_SRC_H:  prdata = 64'(src_h_q);
      REG_TGT_W:  prdata = 64'(tgt_w_q);
      REG_TGT_H:  prdata = 64'(tgt_h_q);
      REG_NORM:   prdata = 64'(norm_q);
      REG_MEANS:  prdata = 64'(means_q);
      REG_INVSTD: prdata = 64'(invs_q);
      default:    prdata = '0;
    endcase
  end

  // Effective sizes, saturated to the supported range
  always_comb begin
    if (src_w_q == '0) cfg.in_w = SRC_DIM_W'(1);
    else if (11'(src_w_q) > 11'(MAX_SOURCE_DIM)) cfg.in_w = SRC_DIM_W'(MAX_SOURCE_DIM);
    else cfg.in_w = SRC_DIM_W'(src_w_q);
    if (src_h_q == '0) cfg.in_h = SRC_DIM_W'(1);
    else if (11'(src_h_q) > 11'(MAX_SOURCE_DIM)) cfg.in_h = SRC_DIM_W'(MAX_SOURCE_DIM);
    else cfg.in_h = SRC_DIM_W'(src_h_q);
    if (tgt_w_q == '0) cfg.out_w = TGT_DIM_W'(1);
    else if (13'(tgt_w_q) > 13'(MAX_TARGET_DIM)) cfg.out_w = TGT_DIM_W'(MAX_TARGET_DIM);
    else cfg.out_w = TGT_DIM_W'(tgt_w_q);
    if (tgt_h_q == '0) cfg.out_h = TGT_DIM_W'(1);
    else if (13'(tgt_h_q) > 13'(MAX_TARGET_DIM)) cfg.out_h = TGT_DIM_W'(MAX_TARGET_DIM);
    else cfg.out_h = TGT_DIM_W'(tgt_h_q);
    cfg.norm  = norm_q;
    cfg.means = means_q;
    cfg.invs  = invs_q;
  end

  bir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .out_ready_i (out_ready_i),
    .st_i        (sts),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  bir_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .st_o          (sts),
    .channel_i     (channel_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .pixel_i       (pixel_i),
    .value_o       (value_o),
    .out_channel_o (out_channel_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .error_o       (error_o)
  );

endmodule

@@ hw/rtl/bir_div.sv @@
// Restoring divider: quotient of dividend*2^14 over divisor, one bit a cycle.
// Depends on bir_pkg.
module bir_div import bir_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [PROD_W-1:0]   dividend_i,
  input  logic [DEN_W-1:0]    divisor_i,
  output logic [QUO_W-1:0]    quotient_o,
  output logic                done_o
);

  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]  den_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DEN_W:0]    rem_sh, diff;

  // Trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem_q, quo_q[QUO_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    if (!diff[DEN_W]) begin
      rem_d = diff[DEN_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[DEN_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], 1'b0};
    end
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= {dividend_i, {FRAC_W{1'b0}}};
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

@@ hw/rtl/bir_dp.sv @@
// Datapath: frame store, position dividers, weights, MAC pipeline, output scaling.
// Depends on bir_pkg and bir_div.
module bir_dp import bir_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  cmd_t                cmd_i,
  output sts_t                st_o,
  input  logic [CH_W-1:0]     channel_i,
  input  logic [COORD_W-1:0]  row_i,
  input  logic [COORD_W-1:0]  col_i,
  input  logic [PIX_W-1:0]    pixel_i,
  output logic [VAL_W-1:0]    value_o,
  output logic [CH_W-1:0]     out_channel_o,
  output logic [COORD_W-1:0]  out_row_o,
  output logic [COORD_W-1:0]  out_col_o,
  output logic                error_o
);

  // Request
  logic [CH_W-1:0]    req_ch_q;
  logic [COORD_W-1:0] req_row_q, req_col_q;
  logic               err_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_ch_q  <= channel_i;
      req_row_q <= row_i;
      req_col_q <= col_i;
    end
    if (cmd_i.setup) err_q <= st_o.req_err;
  end

  assign st_o.req_err = (req_ch_q >= CH_W'(CHANNELS))
                     || ({1'b0, req_row_q} >= cfg_i.out_h)
                     || ({1'b0, req_col_q} >= cfg_i.out_w);

  // Per-axis position: axis 0 horizontal, axis 1 vertical
  logic signed [NUM_W-1:0]  num_q  [2];
  logic [PROD_W-1:0]        dvd    [2];
  logic [DEN_W-1:0]         den    [2];
  logic [QUO_W-1:0]         quo    [2];
  logic                     ddone  [2];
  logic [SPOS_W-1:0]        s_q    [2];
  logic [FRAC_W-1:0]        t_q    [2];
  logic [2*FRAC_W-1:0]      t2_q   [2];
  logic [3*FRAC_W-1:0]      t3_q   [2];
  wgt_t                     w_q    [2];
  logic [COORD_W-1:0]       ocrd   [2];
  logic [SRC_DIM_W-1:0]     insz   [2];
  logic [TGT_DIM_W-1:0]     outsz  [2];
  logic [PROD_W-1:0]        prod   [2];
  logic signed [NUM_W-1:0]  num_d  [2];

  always_comb begin
    ocrd[0]  = req_col_q;
    ocrd[1]  = req_row_q;
    insz[0]  = cfg_i.in_w;
    insz[1]  = cfg_i.in_h;
    outsz[0] = cfg_i.out_w;
    outsz[1] = cfg_i.out_h;
    for (int a = 0; a < 2; a++) begin
      prod[a]  = PROD_W'({ocrd[a], 1'b1}) * PROD_W'(insz[a]);
      num_d[a] = $signed({1'b0, prod[a]}) - $signed({{(NUM_W-TGT_DIM_W){1'b0}}, outsz[a]});
      den[a]   = {outsz[a], 1'b0};
      // A negative numerator lies above -den: floor is -1, remainder num+den
      dvd[a]   = num_q[a][NUM_W-1]
               ? PROD_W'(num_q[a] + $signed({{(NUM_W-DEN_W){1'b0}}, den[a]}))
               : num_q[a][PROD_W-1:0];
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    bir_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (cmd_i.div_start),
      .dividend_i (dvd[a]),
      .divisor_i  (den[a]),
      .quotient_o (quo[a]),
      .done_o     (ddone[a])
    );
  end

  // Both dividers run in lockstep
  assign st_o.div_done = ddone[0] && ddone[1];

  // Position, powers of t and weights
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      if (cmd_i.setup) num_q[a] <= num_d[a];
      if (cmd_i.wt2) begin
        s_q[a]  <= num_q[a][NUM_W-1] ? '1 : quo[a][FRAC_W+SPOS_W-1:FRAC_W];
        t_q[a]  <= quo[a][FRAC_W-1:0];
        t2_q[a] <= (2*FRAC_W)'(quo[a][FRAC_W-1:0]) * (2*FRAC_W)'(quo[a][FRAC_W-1:0]);
      end
      if (cmd_i.wt3) t3_q[a] <= (3*FRAC_W)'(t2_q[a]) * (3*FRAC_W)'(t_q[a]);
      if (cmd_i.wgt) w_q[a] <= calc_weights(t_q[a], t2_q[a], t3_q[a]);
    end
  end

  // Frame store, single port
  logic [PIX_W-1:0]  store_q [STORE_DEPTH];
  logic [PIX_W-1:0]  rdata_q;
  logic              we;
  logic [ADDR_W-1:0] addr;

  assign we = cmd_i.wr && (channel_i < CH_W'(CHANNELS))
           && (row_i < COORD_W'(MAX_SOURCE_DIM)) && (col_i < COORD_W'(MAX_SOURCE_DIM));

  always_comb begin
    if (cmd_i.wr)
      addr = ADDR_W'({channel_i, row_i[SRC_IDX_W-1:0], col_i[SRC_IDX_W-1:0]});
    else
      addr = ADDR_W'({req_ch_q,
                      clamp_tap(s_q[1], cmd_i.tap[3:2], cfg_i.in_h),
                      clamp_tap(s_q[0], cmd_i.tap[1:0], cfg_i.in_w)});
  end

  always_ff @(posedge clk_i) begin
    if (we) store_q[addr] <= pixel_i;
    else if (cmd_i.fetch) rdata_q <= store_q[addr];
  end

  // MAC pipeline: horizontal sum, vertical product, accumulate
  logic                    b_vld_q, hv_q, vv_q, sdone_q;
  logic [3:0]              b_tap_q;
  logic [1:0]              hk_q, vk_q;
  logic signed [H_W-1:0]   h_q, h_d;
  logic signed [26:0]      hprod;
  logic signed [VP_W-1:0]  vprod_q;
  logic signed [SUM_W-1:0] sum_q;
  wgt_val_t                wx, wy;

  always_comb begin
    wx    = w_q[0][b_tap_q[1:0]];
    wy    = w_q[1][hk_q];
    hprod = $signed(wx) * $signed({1'b0, rdata_q});
    h_d   = ((b_tap_q[1:0] == 2'd0) ? '0 : h_q) + H_W'(hprod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      hv_q    <= 1'b0;
      vv_q    <= 1'b0;
      sdone_q <= 1'b0;
    end else begin
      b_vld_q <= cmd_i.fetch;
      hv_q    <= b_vld_q && (b_tap_q[1:0] == 2'd3);
      vv_q    <= hv_q;
      sdone_q <= vv_q && (vk_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i) begin
    b_tap_q <= cmd_i.tap;
    if (b_vld_q) h_q <= h_d;
    hk_q <= b_tap_q[3:2];
    if (hv_q) vprod_q <= $signed(wy) * h_q;
    vk_q <= hk_q;
    if (cmd_i.fetch && cmd_i.tap == 4'd0) sum_q <= '0;
    else if (vv_q) sum_q <= sum_q + {{(SUM_W-VP_W){vprod_q[VP_W-1]}}, vprod_q};
  end

  assign st_o.sum_done = sdone_q;

  // Output scaling: raw rounding or mean, reciprocal std and /255
  logic signed [15:0]      mean;
  logic [15:0]             inv;
  logic signed [SUM_W-1:0] e;
  logic signed [24:0]      m255;
  logic                    sign_q;
  logic [MAG_W-1:0]        mag_q;
  logic [35:0]             plo_q;
  logic [34:0]             phi_q;
  logic [55:0]             ptot;
  logic [Y_W-1:0]          y_q;
  logic [Y_W+RECIP_W-1:0]  yr;
  logic [Y_W-1:0]          q_q;
  logic [VAL_W-1:0]        val;

  always_comb begin
    case (req_ch_q)
      2'd0: begin mean = $signed(cfg_i.means[15:0]);  inv = cfg_i.invs[15:0];  end
      2'd1: begin mean = $signed(cfg_i.means[31:16]); inv = cfg_i.invs[31:16]; end
      2'd2: begin mean = $signed(cfg_i.means[47:32]); inv = cfg_i.invs[47:32]; end
      default: begin mean = '0; inv = 16'd4096; end
    endcase
    m255 = ($signed({{9{mean[15]}}, mean}) <<< 8) - $signed({{9{mean[15]}}, mean});
    e    = cfg_i.norm ? sum_q - ($signed({{(SUM_W-25){m255[24]}}, m255}) <<< 14) : sum_q;
    ptot = {1'b0, phi_q, 20'd0} + {20'd0, plo_q} + (56'd255 << 29);
    yr   = (Y_W+RECIP_W)'(y_q) * (Y_W+RECIP_W)'(RECIP_255);
    // Zero on error, else saturate the signed result to the value range
    if (err_q) val = '0;
    else if (!sign_q) val = (q_q > Y_W'(23'h7FFFFF)) ? 24'h7FFFFF : q_q[VAL_W-1:0];
    else val = (q_q > Y_W'(24'h800000)) ? 24'h800000 : VAL_W'(-q_q[VAL_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.nrm1) begin
      sign_q <= e[SUM_W-1];
      mag_q  <= e[SUM_W-1] ? MAG_W'(-e) : MAG_W'(e);
    end
    if (cmd_i.nrm2) begin
      plo_q <= 36'(mag_q[19:0]) * 36'(inv);
      phi_q <= 35'(mag_q[MAG_W-1:20]) * 35'(inv);
    end
    if (cmd_i.nrm3) begin
      if (cfg_i.norm) y_q <= ptot[30+Y_W-1:30];
      else y_q <= Y_W'((mag_q + MAG_W'(1 << 17)) >> 18);
    end
    if (cmd_i.nrm4) q_q <= cfg_i.norm ? Y_W'(yr >> RECIP_SH) : y_q;
    if (cmd_i.load_out) begin
      value_o       <= val;
      out_channel_o <= req_ch_q;
      out_row_o     <= req_row_q;
      out_col_o     <= req_col_q;
      error_o       <= err_q;
    end
  end

endmodule

@@ hw/rtl/bir_ctrl.sv @@
// Controller state machine: sequences request setup, division, fetch and scaling.
// Depends on bir_pkg and the assertion macro header.
`include "bicubic_image_resampler_assert.svh"
module bir_ctrl import bir_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic action_i,
  input  logic out_ready_i,
  input  sts_t st_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SETUP  = 14'b00000000000010,
    S_DIVST  = 14'b00000000000100,
    S_DIV    = 14'b00000000001000,
    S_WT2    = 14'b00000000010000,
    S_WT3    = 14'b00000000100000,
    S_WGT    = 14'b00000001000000,
    S_FETCH  = 14'b00000010000000,
    S_DRAIN  = 14'b00000100000000,
    S_NRM1   = 14'b00001000000000,
    S_NRM2   = 14'b00010000000000,
    S_NRM3   = 14'b00100000000000,
    S_NRM4   = 14'b01000000000000,
    S_FINISH = 14'b10000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] tap_q, tap_d;
  logic       out_valid_q, out_valid_d;
  logic       acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    tap_d     = tap_q;
    cmd_o     = '0;
    cmd_o.tap = tap_q;
    case (state_q)
      S_IDLE: begin
        if (acc && action_i == ACT_WRITE) cmd_o.wr = 1'b1;
        if (acc && action_i == ACT_COMPUTE) begin
          cmd_o.latch = 1'b1;
          state_d     = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = st_i.req_err ? S_FINISH : S_DIVST;
      end
      S_DIVST: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV:   if (st_i.div_done) state_d = S_WT2;
      S_WT2: begin
        cmd_o.wt2 = 1'b1;
        state_d   = S_WT3;
      end
      S_WT3: begin
        cmd_o.wt3 = 1'b1;
        state_d   = S_WGT;
      end
      S_WGT: begin
        cmd_o.wgt = 1'b1;
        tap_d     = '0;
        state_d   = S_FETCH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        tap_d       = tap_q + 1'b1;
        if (tap_q == 4'd15) state_d = S_DRAIN;
      end
      S_DRAIN: if (st_i.sum_done) state_d = S_NRM1;
      S_NRM1: begin
        cmd_o.nrm1 = 1'b1;
        state_d    = S_NRM2;
      end
      S_NRM2: begin
        cmd_o.nrm2 = 1'b1;
        state_d    = S_NRM3;
      end
      S_NRM3: begin
        cmd_o.nrm3 = 1'b1;
        state_d    = S_NRM4;
      end
      S_NRM4: begin
        cmd_o.nrm4 = 1'b1;
        state_d    = S_FINISH;
      end
      S_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      out_valid_q <= out_valid_d;
    end
  end

  `BIR_ASSERT_IMP(a_div_done_in_div, st_i.div_done, state_q == S_DIV)
  `BIR_ASSERT_IMP(a_sum_done_in_drain, st_i.sum_done, state_q == S_DRAIN)
  `BIR_ASSERT_NXT(a_load_sets_valid, cmd_o.load_out, out_valid_q)

endmodule
